@@ hw/rtl/srrb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_pkg
// Shared types, widths and constants of the selective-repeat reorder buffer.
// ----------------------------------------------------------------------------
package srrb_pkg;

  localparam int SEQ_W        = 32;
  localparam int WORD_W       = 64;
  localparam int BC_W         = 4;
  localparam int BYTES_W      = 10;
  localparam int CFG_W        = 5;
  localparam int MAX_BC       = 8;

  localparam int MAX_WINDOW_DEF    = 16;
  localparam int MAX_PKT_WORDS_DEF = 64;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd16;
  localparam logic [SEQ_W-1:0] EMPTY_SEQ    = 32'hFFFF_FFFF;

  // item queue between front and back
  localparam int FQ_DEPTH = 2;

  // remainder unit: sequence bits consumed per cycle
  localparam int MOD_BITS   = 8;
  localparam int MOD_CYCLES = SEQ_W / MOD_BITS;

  typedef enum logic {
    OP_STORE    = 1'b0,
    OP_RETRIEVE = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] word;
    logic [BC_W-1:0]   bc;
    logic              last;
  } item_t;

  // counts above eight bytes count as eight
  function automatic logic [BC_W-1:0] clamp_bc(input logic [BC_W-1:0] bc);
    logic [BC_W-1:0] r;
    r = bc;
    if (bc > BC_W'(MAX_BC)) r = BC_W'(MAX_BC);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/srrb_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srrb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/srrb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module srrb_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         cmd_i,
  input  wire logic [srrb_pkg::WORD_W-1:0]  data_word_i,
  input  wire logic [srrb_pkg::BC_W-1:0]    byte_count_i,
  input  wire logic                         last_word_i,
  output logic                              q_valid_o,
  output srrb_pkg::item_t                   q_item_o,
  input  wire logic                         q_pop_i
);

  localparam int PTR_W = (srrb_pkg::FQ_DEPTH > 1) ? $clog2(srrb_pkg::FQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(srrb_pkg::FQ_DEPTH + 1);

  srrb_pkg::item_t   fifo_q [srrb_pkg::FQ_DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  cnt_q;
  srrb_pkg::item_t   item_c;
  logic              push, pop;

  always_comb begin
    item_c.op   = cmd_i ? srrb_pkg::OP_RETRIEVE : srrb_pkg::OP_STORE;
    item_c.word = data_word_i;
    item_c.bc   = srrb_pkg::clamp_bc(byte_count_i);
    item_c.last = last_word_i;
  end

  assign in_stall_o = (cnt_q == CNT_W'(srrb_pkg::FQ_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= item_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(srrb_pkg::FQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(srrb_pkg::FQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/srrb_mod.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_mod
// Multi-cycle remainder of a sequence number by the window size,
// eight dividend bits per cycle.
// ----------------------------------------------------------------------------
module srrb_mod #(
  parameter int MAX_WINDOW = srrb_pkg::MAX_WINDOW_DEF,
  localparam int WW = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [srrb_pkg::SEQ_W-1:0]  value_i,
  input  wire logic [WW-1:0]               div_i,
  output logic                             done_o,
  output logic [WW-1:0]                    rem_o
);

  localparam int CW = $clog2(srrb_pkg::MOD_CYCLES + 1);

  logic [srrb_pkg::SEQ_W-1:0] val_q;
  logic [WW-1:0]              rem_q, rem_c;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q, done_q;

  // restoring steps: remainder stays below the divisor, so one subtract suffices
  always_comb begin
    logic [WW:0] t;
    rem_c = rem_q;
    for (int b = 0; b < srrb_pkg::MOD_BITS; b++) begin
      t = {rem_c, val_q[srrb_pkg::SEQ_W-1-b]};
      if (t >= {1'b0, div_i}) t = t - {1'b0, div_i};
      rem_c = t[WW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      rem_q <= '0;
    end else if (busy_q) begin
      val_q <= val_q << srrb_pkg::MOD_BITS;
      rem_q <= rem_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(srrb_pkg::MOD_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/srrb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srrb_back
// Executes queued items: writes packet words into the packet store,
// emits retrieved packets or an empty result through the output register, rescans slots.
// ----------------------------------------------------------------------------
module srrb_back #(
  parameter int MAX_WINDOW       = srrb_pkg::MAX_WINDOW_DEF,
  parameter int MAX_PACKET_WORDS = srrb_pkg::MAX_PKT_WORDS_DEF,
  localparam int WW = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [WW-1:0]                 win_i,
  input  wire logic                          q_valid_i,
  input  srrb_pkg::item_t                    q_item_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [srrb_pkg::WORD_W-1:0]        out_word_o,
  output logic [srrb_pkg::BC_W-1:0]          out_byte_count_o,
  output logic                               out_last_o,
  output logic [srrb_pkg::BYTES_W-1:0]       packet_bytes_o,
  output logic [srrb_pkg::SEQ_W-1:0]         packet_seq_o,
  output logic                               empty_res_o
);

  localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW    = $clog2(MAX_PACKET_WORDS + 1);
  localparam int DEPTH = MAX_WINDOW * MAX_PACKET_WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = srrb_pkg::BYTES_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SMOD  = 3'd1;
  localparam logic [2:0] S_RMOD  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [MAX_WINDOW-1:0]       valid_q, valid_d;
  logic [srrb_pkg::SEQ_W-1:0]  seq_q   [MAX_WINDOW];
  logic [srrb_pkg::SEQ_W-1:0]  seq_d   [MAX_WINDOW];
  logic [BW-1:0]               bytes_q [MAX_WINDOW];
  logic [BW-1:0]               bytes_d [MAX_WINDOW];

  logic [srrb_pkg::SEQ_W-1:0]  low_q, low_d;
  logic                        lv_q, lv_d;
  logic [PW-1:0]               pos_q, pos_d;
  logic [SW-1:0]               sslot_q, sslot_d;
  logic [srrb_pkg::SEQ_W-1:0]  sseq_q, sseq_d;
  logic [BW-1:0]               stot_q, stot_d;
  srrb_pkg::item_t             cur_q, cur_d;

  logic [SW-1:0]               rslot_q, rslot_d;
  logic [BW-1:0]               rbytes_q, rbytes_d;
  logic [srrb_pkg::SEQ_W-1:0]  rseq_q, rseq_d;
  logic [PW-1:0]               widx_q, widx_d;
  logic [PW-1:0]               lastw_q, lastw_d;
  logic [SW-1:0]               sidx_q, sidx_d;

  logic                        ov_q, ov_d;
  logic [srrb_pkg::WORD_W-1:0] ow_q, ow_d;
  logic [srrb_pkg::BC_W-1:0]   obc_q, obc_d;
  logic                        olast_q, olast_d;
  logic [BW-1:0]               obytes_q, obytes_d;
  logic [srrb_pkg::SEQ_W-1:0]  oseq_q, oseq_d;
  logic                        oempty_q, oempty_d;

  logic                        mod_start, mod_done;
  logic [srrb_pkg::SEQ_W-1:0]  mod_val;
  logic [WW-1:0]               mod_rem;
  logic [SW-1:0]               rem_slot;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [srrb_pkg::WORD_W-1:0] ram_rdata;

  logic [SW-1:0]               rd_idx;
  logic                        rd_valid;
  logic [srrb_pkg::SEQ_W-1:0]  rd_seq;
  logic [BW-1:0]               rd_bytes;
  logic                        out_free;

  srrb_mod #(.MAX_WINDOW(MAX_WINDOW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_val),
    .div_i   (win_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  srrb_ram #(.WIDTH(srrb_pkg::WORD_W), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cur_d.word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rem_slot = SW'(mod_rem);
  assign rd_idx   = (state_q == S_SCAN) ? sidx_q : rem_slot;
  assign rd_valid = valid_q[rd_idx];
  assign rd_seq   = seq_q[rd_idx];
  assign rd_bytes = bytes_q[rd_idx];
  assign out_free = !ov_q || !out_stall_i;
  assign ram_raddr = AW'(AW'(rslot_q) * AW'(MAX_PACKET_WORDS) + AW'(widx_q));

  always_comb begin
    logic                       st_go;
    logic [SW-1:0]              st_slot;
    logic [srrb_pkg::SEQ_W-1:0] st_seq;
    logic [BW-1:0]              st_tot, tot_n;
    logic [BW-1:0]              nw, off, diff;
    logic                       is_last;

    state_d  = state_q;
    valid_d  = valid_q;
    seq_d    = seq_q;
    bytes_d  = bytes_q;
    low_d    = low_q;
    lv_d     = lv_q;
    pos_d    = pos_q;
    sslot_d  = sslot_q;
    sseq_d   = sseq_q;
    stot_d   = stot_q;
    cur_d    = cur_q;
    rslot_d  = rslot_q;
    rbytes_d = rbytes_q;
    rseq_d   = rseq_q;
    widx_d   = widx_q;
    lastw_d  = lastw_q;
    sidx_d   = sidx_q;
    ov_d     = ov_q && out_stall_i;
    ow_d     = ow_q;
    obc_d    = obc_q;
    olast_d  = olast_q;
    obytes_d = obytes_q;
    oseq_d   = oseq_q;
    oempty_d = oempty_q;

    q_pop_o   = 1'b0;
    mod_start = 1'b0;
    mod_val   = q_item_i.word[srrb_pkg::WORD_W-1 -: srrb_pkg::SEQ_W];
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    st_go     = 1'b0;
    st_slot   = sslot_q;
    st_seq    = sseq_q;
    st_tot    = stot_q;
    tot_n     = stot_q;
    nw        = '0;
    off       = '0;
    diff      = '0;
    is_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          if (q_item_i.op == srrb_pkg::OP_RETRIEVE) begin
            mod_start = 1'b1;
            mod_val   = low_q;
            state_d   = S_RMOD;
          end else if (pos_q == '0) begin
            // first word: slot comes from the remainder unit
            mod_start = 1'b1;
            state_d   = S_SMOD;
          end else begin
            st_go = 1'b1;
          end
        end
      end
      S_SMOD: begin
        if (mod_done) begin
          st_go   = 1'b1;
          st_slot = rem_slot;
          st_seq  = cur_q.word[srrb_pkg::WORD_W-1 -: srrb_pkg::SEQ_W];
          st_tot  = '0;
          sslot_d = rem_slot;
          sseq_d  = st_seq;
          state_d = S_IDLE;
        end
      end
      S_RMOD: begin
        if (mod_done) begin
          rslot_d = rem_slot;
          if (!lv_q || !rd_valid) begin
            state_d = S_EMPTY;
          end else begin
            rbytes_d = rd_bytes;
            rseq_d   = rd_seq;
            nw = BW'((rd_bytes + BW'(7)) >> 3);
            if (nw == '0) nw = BW'(1);
            if (nw > BW'(MAX_PACKET_WORDS)) nw = BW'(MAX_PACKET_WORDS);
            lastw_d = PW'(nw - BW'(1));
            widx_d  = '0;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          is_last  = (widx_q == lastw_q);
          off      = BW'({widx_q, 3'b000});
          diff     = rbytes_q - off;
          ov_d     = 1'b1;
          ow_d     = ram_rdata;
          olast_d  = is_last;
          obytes_d = rbytes_q;
          oseq_d   = rseq_q;
          oempty_d = 1'b0;
          if (rbytes_q < off) begin
            obc_d = '0;
          end else if (is_last) begin
            obc_d = diff[srrb_pkg::BC_W-1:0];
          end else begin
            obc_d = srrb_pkg::BC_W'(srrb_pkg::MAX_BC);
          end
          if (is_last) begin
            valid_d[rslot_q] = 1'b0;
            low_d   = srrb_pkg::EMPTY_SEQ;
            lv_d    = 1'b0;
            sidx_d  = '0;
            state_d = S_SCAN;
          end else begin
            widx_d  = widx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          ov_d     = 1'b1;
          ow_d     = '0;
          obc_d    = '0;
          olast_d  = 1'b0;
          obytes_d = '0;
          oseq_d   = '0;
          oempty_d = 1'b1;
          low_d    = srrb_pkg::EMPTY_SEQ;
          lv_d     = 1'b0;
          sidx_d   = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        // one slot per cycle; slots beyond the window are ignored
        if ((WW'(sidx_q) < win_i) && rd_valid && (!lv_q || rd_seq < low_q)) begin
          low_d = rd_seq;
          lv_d  = 1'b1;
        end
        if (sidx_q == SW'(MAX_WINDOW - 1)) begin
          state_d = S_IDLE;
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (st_go) begin
      if (pos_q < PW'(MAX_PACKET_WORDS)) begin
        ram_we    = 1'b1;
        ram_waddr = AW'(AW'(st_slot) * AW'(MAX_PACKET_WORDS) + AW'(pos_q));
        tot_n     = st_tot + BW'(cur_d.bc);
        pos_d     = pos_q + 1'b1;
      end else begin
        tot_n = st_tot;
      end
      stot_d = tot_n;
      if (cur_d.last) begin
        valid_d[st_slot] = 1'b1;
        seq_d[st_slot]   = st_seq;
        bytes_d[st_slot] = tot_n;
        if (!lv_q || st_seq < low_q) begin
          low_d = st_seq;
          lv_d  = 1'b1;
        end
        pos_d  = '0;
        stot_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    rbytes_q <= rbytes_d;
    rseq_q   <= rseq_d;
    lastw_q  <= lastw_d;
    ow_q     <= ow_d;
    obc_q    <= obc_d;
    olast_q  <= olast_d;
    obytes_q <= obytes_d;
    oseq_q   <= oseq_d;
    oempty_q <= oempty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        seq_q[i]   <= '0;
        bytes_q[i] <= '0;
      end
      low_q   <= srrb_pkg::EMPTY_SEQ;
      lv_q    <= 1'b0;
      pos_q   <= '0;
      sslot_q <= '0;
      sseq_q  <= '0;
      stot_q  <= '0;
      rslot_q <= '0;
      widx_q  <= '0;
      sidx_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      seq_q   <= seq_d;
      bytes_q <= bytes_d;
      low_q   <= low_d;
      lv_q    <= lv_d;
      pos_q   <= pos_d;
      sslot_q <= sslot_d;
      sseq_q  <= sseq_d;
      stot_q  <= stot_d;
      rslot_q <= rslot_d;
      widx_q  <= widx_d;
      sidx_q  <= sidx_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign out_word_o       = ow_q;
  assign out_byte_count_o = obc_q;
  assign out_last_o       = olast_q;
  assign packet_bytes_o   = obytes_q;
  assign packet_seq_o     = oseq_q;
  assign empty_res_o      = oempty_q;

endmodule
`default_nettype wire

@@ hw/rtl/selective_repeat_reorder_buffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_reorder_buffer
// Receive-side reorder buffer for selective-repeat packet recovery.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): store items carry one packet word
// each, the first word's top 32 bits being the sequence number; a retrieve
// item asks for the lowest-numbered held packet. Items pass a two-entry queue
// into the executing back end.
// Output channel (out_valid_o / out_stall_i): one item per retrieved word,
// or one item flagged empty_res_o when nothing is held.
// Sequencing: a continuing store word is written to the packet store in the
// cycle it is popped; a first word holds the back end through the pop, the
// remainder unit and its done cycle. A retrieve finds its slot likewise,
// reads each word from the store to the output register, then rescans slots.
// Reset clears all slots and the window register to 16; no clearing pass.
// When the receiver stalls the output register holds and the back end waits
// before its next output; the input queue keeps taking items until it fills.
// cfg_valid_i / cfg_data_i write the window register; write it only while idle.
module selective_repeat_reorder_buffer #(
  parameter int MAX_WINDOW       = srrb_pkg::MAX_WINDOW_DEF,
  parameter int MAX_PACKET_WORDS = srrb_pkg::MAX_PKT_WORDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [srrb_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [srrb_pkg::WORD_W-1:0]   data_word_i,
  input  wire logic [srrb_pkg::BC_W-1:0]     byte_count_i,
  input  wire logic                          last_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [srrb_pkg::WORD_W-1:0]        out_word_o,
  output logic [srrb_pkg::BC_W-1:0]          out_byte_count_o,
  output logic                               out_last_o,
  output logic [srrb_pkg::BYTES_W-1:0]       packet_bytes_o,
  output logic [srrb_pkg::SEQ_W-1:0]         packet_seq_o,
  output logic                               empty_res_o
);

  localparam int WW = $clog2(MAX_WINDOW + 1);

  logic [srrb_pkg::CFG_W-1:0] win_q;
  logic [WW-1:0]              win_eff;
  logic                       q_valid, q_pop;
  srrb_pkg::item_t            q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= srrb_pkg::WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_q <= cfg_data_i;
    end
  end

  // zero acts as one, oversize as the full window
  always_comb begin
    if (win_q == '0) begin
      win_eff = WW'(1);
    end else if (int'(win_q) > MAX_WINDOW) begin
      win_eff = WW'(MAX_WINDOW);
    end else begin
      win_eff = WW'(win_q);
    end
  end

  srrb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  srrb_back #(
    .MAX_WINDOW       (MAX_WINDOW),
    .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .win_i            (win_eff),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_word_o       (out_word_o),
    .out_byte_count_o (out_byte_count_o),
    .out_last_o       (out_last_o),
    .packet_bytes_o   (packet_bytes_o),
    .packet_seq_o     (packet_seq_o),
    .empty_res_o      (empty_res_o)
  );

endmodule
`default_nettype wire
